FILE: rtl/msrb_pkg.sv
package msrb_pkg;

    localparam int SCREEN_WIDTH   = 128;
    localparam int SCREEN_HEIGHT  = 96;
    localparam int BYTES_PER_LINE = (SCREEN_WIDTH + 7) / 8;
    localparam int FRAME_BYTES    = BYTES_PER_LINE * SCREEN_HEIGHT;
    localparam int ADDR_W         = $clog2(FRAME_BYTES);
    localparam int ROW_PIXELS     = 16;
    localparam int SPAN_BYTES     = (ROW_PIXELS + 7) / 8 + 1;
    localparam int SPAN_W         = SPAN_BYTES * 8;
    localparam int BYTE_IDX_W     = $clog2(SPAN_BYTES + 1);
    localparam int COORD_W        = 12;
    localparam int READ_IDX_W     = 11;
    localparam int QDEPTH         = 2;
    localparam int QPTR_W         = $clog2(QDEPTH);
    localparam int QCNT_W         = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_REPLACE,
        OP_INVERT,
        OP_OR,
        OP_READ
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_MERGE,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [SPAN_W-1:0]  data;
        logic [SPAN_W-1:0]  mask;
        logic [ADDR_W-1:0]  addr;
        logic               flag;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

FILE: rtl/msrb_front.sv
module msrb_front (
    input  logic [1:0]                          i_opcode,
    input  logic [msrb_pkg::ROW_PIXELS-1:0]     i_sprite_row,
    input  logic signed [7:0]                   i_x_pos,
    input  logic signed [7:0]                   i_y_row,
    input  logic [msrb_pkg::READ_IDX_W-1:0]     i_read_index,
    output msrb_pkg::t_cmd                      o_cmd
);

    logic signed [msrb_pkg::COORD_W-1:0] y;
    logic signed [msrb_pkg::COORD_W-1:0] col;
    logic signed [7:0]                   x_byte;
    logic                                y_ok;
    logic [msrb_pkg::ROW_PIXELS-1:0]     on;
    logic [msrb_pkg::ROW_PIXELS-1:0]     bits;
    logic [msrb_pkg::ADDR_W-1:0]         row_base;
    msrb_pkg::t_op                       op;

    always_comb begin
        op   = msrb_pkg::t_op'(i_opcode);
        y    = msrb_pkg::COORD_W'(i_y_row);
        y_ok = (y >= 0) && (y < $signed(msrb_pkg::COORD_W'(msrb_pkg::SCREEN_HEIGHT)));
        col  = '0;
        for (int k = 0; k < msrb_pkg::ROW_PIXELS; k++) begin
            col = msrb_pkg::COORD_W'(i_x_pos) + msrb_pkg::COORD_W'(k);
            on[msrb_pkg::ROW_PIXELS-1-k] = y_ok && (col >= 0)
                && (col < $signed(msrb_pkg::COORD_W'(msrb_pkg::SCREEN_WIDTH)));
        end
        bits     = (op == msrb_pkg::OP_INVERT) ? ~i_sprite_row : i_sprite_row;
        x_byte   = i_x_pos >>> 3;
        row_base = msrb_pkg::ADDR_W'(y) * msrb_pkg::ADDR_W'(msrb_pkg::BYTES_PER_LINE);

        o_cmd.op   = op;
        o_cmd.data = msrb_pkg::SPAN_W'({bits, 8'h00}) >> i_x_pos[2:0];
        o_cmd.mask = msrb_pkg::SPAN_W'({on, 8'h00}) >> i_x_pos[2:0];
        unique case (op)
            msrb_pkg::OP_READ: begin
                o_cmd.addr = msrb_pkg::ADDR_W'(i_read_index);
                o_cmd.flag = i_read_index
                             < msrb_pkg::READ_IDX_W'(msrb_pkg::FRAME_BYTES);
            end
            default: begin
                o_cmd.addr = row_base + msrb_pkg::ADDR_W'(x_byte);
                o_cmd.flag = ~&on;
            end
        endcase
    end

endmodule

FILE: rtl/msrb_queue.sv
module msrb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  msrb_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output msrb_pkg::t_cmd  o_cmd,
    output msrb_pkg::t_qstat o_stat
);

    msrb_pkg::t_cmd                 r_slot [msrb_pkg::QDEPTH];
    logic [msrb_pkg::QPTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [msrb_pkg::QPTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [msrb_pkg::QCNT_W-1:0]    r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == msrb_pkg::QPTR_W'(msrb_pkg::QDEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == msrb_pkg::QPTR_W'(msrb_pkg::QDEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd        = r_slot[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == msrb_pkg::QCNT_W'(msrb_pkg::QDEPTH));

endmodule

FILE: rtl/msrb_back.sv
module msrb_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  msrb_pkg::t_cmd   i_cmd,
    input  msrb_pkg::t_qstat i_qstat,
    output logic             o_pop,
    output logic             o_clearing,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_read_data,
    output logic             o_row_clipped
);

    logic [7:0]                        r_frame [msrb_pkg::FRAME_BYTES];
    msrb_pkg::t_state                  r_state, n_state;
    msrb_pkg::t_cmd                    r_cmd;
    logic [msrb_pkg::BYTE_IDX_W-1:0]   r_byte;
    logic [msrb_pkg::ADDR_W-1:0]       r_clr_addr;
    logic [7:0]                        r_rd_data;
    logic [7:0]                        r_res_data;
    logic                              r_out_valid;
    logic [7:0]                        r_out_data;
    logic                              r_out_clip;

    logic [msrb_pkg::SPAN_W-1:0]       mask_sh, data_sh;
    logic [7:0]                        mask_b, data_b, merged;
    logic [msrb_pkg::ADDR_W-1:0]       addr_j;
    logic                              active, finished, is_read;

    logic                              pop, rd_en, wr_en, byte_step, clr_step;
    logic                              take_read, load_out;
    logic [msrb_pkg::ADDR_W-1:0]       rd_addr, wr_addr;
    logic [7:0]                        wr_data;

    always_comb begin
        mask_sh  = r_cmd.mask << {r_byte, 3'b000};
        data_sh  = r_cmd.data << {r_byte, 3'b000};
        mask_b   = mask_sh[msrb_pkg::SPAN_W-1 -: 8];
        data_b   = data_sh[msrb_pkg::SPAN_W-1 -: 8];
        active   = |mask_b;
        finished = (r_byte == msrb_pkg::BYTE_IDX_W'(msrb_pkg::SPAN_BYTES));
        addr_j   = r_cmd.addr + msrb_pkg::ADDR_W'(r_byte);
        is_read  = (r_cmd.op == msrb_pkg::OP_READ);
        if (r_cmd.op == msrb_pkg::OP_OR) begin
            merged = r_rd_data | (data_b & mask_b);
        end else begin
            merged = (r_rd_data & ~mask_b) | (data_b & mask_b);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msrb_pkg::ST_CLEAR: begin
                if (r_clr_addr == msrb_pkg::ADDR_W'(msrb_pkg::FRAME_BYTES - 1)) begin
                    n_state = msrb_pkg::ST_IDLE;
                end
            end
            msrb_pkg::ST_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = msrb_pkg::ST_ISSUE;
                end
            end
            msrb_pkg::ST_ISSUE: begin
                if (is_read) begin
                    n_state = r_cmd.flag ? msrb_pkg::ST_MERGE : msrb_pkg::ST_DONE;
                end else if (finished) begin
                    n_state = msrb_pkg::ST_DONE;
                end else if (active) begin
                    n_state = msrb_pkg::ST_MERGE;
                end
            end
            msrb_pkg::ST_MERGE: begin
                n_state = is_read ? msrb_pkg::ST_DONE : msrb_pkg::ST_ISSUE;
            end
            msrb_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = msrb_pkg::ST_IDLE;
                end
            end
            default: n_state = msrb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        pop       = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = addr_j;
        wr_en     = 1'b0;
        wr_addr   = addr_j;
        wr_data   = merged;
        byte_step = 1'b0;
        clr_step  = 1'b0;
        take_read = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            msrb_pkg::ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = r_clr_addr;
                wr_data  = '0;
                clr_step = 1'b1;
            end
            msrb_pkg::ST_IDLE: begin
                pop = !i_qstat.empty;
            end
            msrb_pkg::ST_ISSUE: begin
                if (is_read) begin
                    rd_en   = r_cmd.flag;
                    rd_addr = r_cmd.addr;
                end else begin
                    rd_en     = active && !finished;
                    byte_step = !active && !finished;
                end
            end
            msrb_pkg::ST_MERGE: begin
                if (is_read) begin
                    take_read = 1'b1;
                end else begin
                    wr_en     = 1'b1;
                    byte_step = 1'b1;
                end
            end
            msrb_pkg::ST_DONE: begin
                load_out = !r_out_valid || i_out_ready;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= msrb_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_byte      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (pop) begin
                r_byte <= '0;
            end else if (byte_step) begin
                r_byte <= r_byte + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd      <= i_cmd;
            r_res_data <= '0;
        end else if (take_read) begin
            r_res_data <= r_rd_data;
        end
        if (load_out) begin
            r_out_data <= r_res_data;
            r_out_clip <= !is_read && r_cmd.flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_frame[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_frame[rd_addr];
        end
    end

    assign o_pop         = pop;
    assign o_clearing    = (r_state == msrb_pkg::ST_CLEAR);
    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_out_data;
    assign o_row_clipped = r_out_clip;

endmodule

FILE: rtl/mono_sprite_row_blitter.sv
// Blits 16-pixel rows into a 128 x 96, one-bit-per-pixel frame store and reads back single
// frame bytes. After reset the store is swept to zero, one byte per cycle, so no word is
// accepted until the sweep is done. A word then goes into a two-entry queue; the back end
// runs a read-modify-write over the up to three bytes the row covers on the single-port
// store: it fetches the word, skips each byte outside the row or the screen, reads and then
// writes each byte it changes, closes the row and hands over the result. A read word is
// fetched, its byte is read and taken, and the result is handed over; when the index lies
// beyond the store the byte read is skipped. A stalled result holds the back end in its
// hand-over step. Off-screen pixels are dropped and flagged in o_row_clipped; a read beyond
// the store returns zero.
module mono_sprite_row_blitter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_opcode,
    input  logic [msrb_pkg::ROW_PIXELS-1:0]   i_sprite_row,
    input  logic signed [7:0]                 i_x_pos,
    input  logic signed [7:0]                 i_y_row,
    input  logic [msrb_pkg::READ_IDX_W-1:0]   i_read_index,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_read_data,
    output logic                              o_row_clipped
);

    msrb_pkg::t_cmd   front_cmd;
    msrb_pkg::t_cmd   queue_cmd;
    msrb_pkg::t_qstat qstat;
    logic             pop;
    logic             clearing;
    logic             push;

    assign o_in_ready = !qstat.full && !clearing;
    assign push       = i_in_valid && o_in_ready;

    msrb_front u_front (
        .i_opcode     (i_opcode),
        .i_sprite_row (i_sprite_row),
        .i_x_pos      (i_x_pos),
        .i_y_row      (i_y_row),
        .i_read_index (i_read_index),
        .o_cmd        (front_cmd)
    );

    msrb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_stat  (qstat)
    );

    msrb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (queue_cmd),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_data   (o_read_data),
        .o_row_clipped (o_row_clipped)
    );

endmodule

FILE: rtl/msrb_checker.sv
module msrb_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [7:0]                        o_read_data,
    input logic                              o_row_clipped
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_read_data) && $stable(o_row_clipped))
        else $error("stalled result word changed");

    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_in_ready && !o_out_valid)
        else $error("word taken or result shown during store clear");

    a_read_or_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_row_clipped && (o_read_data != 8'h00)))
        else $error("result carries both read data and clip flag");

endmodule

bind mono_sprite_row_blitter msrb_checker u_msrb_checker (.*);

FILE: sim/mono_sprite_row_blitter_test.sv
module mono_sprite_row_blitter_test;

    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_WORDS = 2000;

    class frame_board;
        logic [7:0] shadow [msrb_pkg::FRAME_BYTES];
        logic [7:0] want_data [$];
        logic       want_clip [$];
        int         faults;

        function new();
            foreach (shadow[i]) begin
                shadow[i] = 8'h00;
            end
            faults = 0;
        endfunction

        function logic blit(msrb_pkg::t_op op, logic [15:0] bits, int x, int y);
            logic hit;
            int   col;
            int   idx;
            int   k;
            hit = 1'b0;
            if (op == msrb_pkg::OP_INVERT) begin
                bits = ~bits;
            end
            for (k = 0; k < msrb_pkg::ROW_PIXELS; k++) begin
                col = x + k;
                if (y < 0 || y >= msrb_pkg::SCREEN_HEIGHT || col < 0
                    || col >= msrb_pkg::SCREEN_WIDTH) begin
                    hit = 1'b1;
                end else begin
                    idx = y * msrb_pkg::BYTES_PER_LINE + col / 8;
                    if (bits[15 - k]) begin
                        shadow[idx][7 - col % 8] = 1'b1;
                    end else if (op != msrb_pkg::OP_OR) begin
                        shadow[idx][7 - col % 8] = 1'b0;
                    end
                end
            end
            return hit;
        endfunction

        function void note_word(msrb_pkg::t_op op, logic [15:0] bits, logic signed [7:0] x,
                                logic signed [7:0] y, logic [10:0] ridx);
            if (op == msrb_pkg::OP_READ) begin
                want_data.push_back(ridx < msrb_pkg::FRAME_BYTES ? shadow[ridx] : 8'h00);
                want_clip.push_back(1'b0);
            end else begin
                want_clip.push_back(blit(op, bits, x, y));
                want_data.push_back(8'h00);
            end
        endfunction

        function void check_word(logic [7:0] data, logic clip);
            logic [7:0] d;
            logic       c;
            if (want_data.size() == 0) begin
                faults++;
                $display("%0t: unexpected word, read_data %h row_clipped %b",
                         $time, data, clip);
                return;
            end
            d = want_data.pop_front();
            c = want_clip.pop_front();
            if (data !== d) begin
                faults++;
                $display("%0t: read_data expected %h actual %h", $time, d, data);
            end
            if (clip !== c) begin
                faults++;
                $display("%0t: row_clipped expected %b actual %b", $time, c, clip);
            end
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_ready;
    logic [1:0]                         i_opcode;
    logic [msrb_pkg::ROW_PIXELS-1:0]    i_sprite_row;
    logic signed [7:0]                  i_x_pos;
    logic signed [7:0]                  i_y_row;
    logic [msrb_pkg::READ_IDX_W-1:0]    i_read_index;
    logic                               o_out_valid;
    logic                               i_out_ready;
    logic [7:0]                         o_read_data;
    logic                               o_row_clipped;

    frame_board board;
    logic       quiet_in;
    logic       quiet_out;

    mono_sprite_row_blitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_sprite_row  (i_sprite_row),
        .i_x_pos       (i_x_pos),
        .i_y_row       (i_y_row),
        .i_read_index  (i_read_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_data   (o_read_data),
        .o_row_clipped (o_row_clipped)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic send_word(msrb_pkg::t_op op, logic [15:0] bits, logic signed [7:0] x,
                             logic signed [7:0] y, logic [10:0] ridx);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode     = op;
        i_sprite_row = bits;
        i_x_pos      = x;
        i_y_row      = y;
        i_read_index = ridx;
        i_in_valid   = 1'b1;
        // hold the word until it is taken
        do @(posedge i_clk); while (!o_in_ready);
        board.note_word(op, bits, x, y, ridx);
    endtask

    initial begin
        int stall;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 63) == 0) begin
                quiet_out = !quiet_out;
            end
            stall = quiet_out ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            board.check_word(o_read_data, o_row_clipped);
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int   n;
        int   v;
        int   ri;
        int   last_x;
        int   last_y;
        msrb_pkg::t_op op;
        logic signed [7:0] x;
        logic signed [7:0] y;

        board        = new();
        quiet_in     = 1'b0;
        quiet_out    = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_out_ready  = 1'b0;
        i_opcode     = msrb_pkg::OP_REPLACE;
        i_sprite_row = '0;
        i_x_pos      = '0;
        i_y_row      = '0;
        i_read_index = '0;
        last_x       = 0;
        last_y       = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(msrb_pkg::OP_REPLACE, 16'hFFFF, 8'sd0, 8'sd0, 11'd0);
        send_word(msrb_pkg::OP_READ, 16'h0000, 8'sd0, 8'sd0, 11'd0);
        send_word(msrb_pkg::OP_READ, 16'h0000, 8'sd0, 8'sd0, 11'd1);
        send_word(msrb_pkg::OP_READ, 16'h0000, 8'sd0, 8'sd0, 11'd2);
        send_word(msrb_pkg::OP_REPLACE, 16'hFFFF, -8'sd15, 8'sd1, 11'd0);
        send_word(msrb_pkg::OP_REPLACE, 16'hA5A5, 8'sd120, 8'sd2, 11'd0);
        send_word(msrb_pkg::OP_REPLACE, 16'hFFFF, 8'sd127, 8'sd95, 11'd0);
        send_word(msrb_pkg::OP_INVERT, 16'h0F0F, 8'sd3, 8'sd10, 11'd0);
        send_word(msrb_pkg::OP_OR, 16'h8001, 8'sd5, 8'sd10, 11'd0);
        send_word(msrb_pkg::OP_READ, 16'h0000, 8'sd0, 8'sd0, 11'd160);
        send_word(msrb_pkg::OP_READ, 16'h0000, 8'sd0, 8'sd0, 11'd161);
        send_word(msrb_pkg::OP_READ, 16'h0000, 8'sd0, 8'sd0, 11'd162);
        send_word(msrb_pkg::OP_OR, 16'h0000, 8'sd0, 8'sd0, 11'd0);
        send_word(msrb_pkg::OP_REPLACE, 16'hFFFF, 8'sd40, -8'sd1, 11'd0);
        send_word(msrb_pkg::OP_REPLACE, 16'hFFFF, 8'sd40, 8'sd96, 11'd0);
        send_word(msrb_pkg::OP_INVERT, 16'h0000, -8'sd128, 8'sd127, 11'h7FF);
        send_word(msrb_pkg::OP_OR, 16'hFFFF, 8'sd127, -8'sd128, 11'h7FF);
        send_word(msrb_pkg::OP_INVERT, 16'h0000, 8'sd112, 8'sd95, 11'd0);
        send_word(msrb_pkg::OP_READ, 16'hFFFF, -8'sd1, -8'sd1, 11'd1535);
        send_word(msrb_pkg::OP_READ, 16'h0000, 8'sd0, 8'sd0, 11'd1534);
        send_word(msrb_pkg::OP_READ, 16'h0000, 8'sd0, 8'sd0, 11'd1536);
        send_word(msrb_pkg::OP_READ, 16'h0000, 8'sd0, 8'sd0, 11'd2047);

        for (n = 0; n < RANDOM_WORDS; n++) begin
            if ($urandom_range(0, 63) == 0) begin
                quiet_in = !quiet_in;
            end
            op = msrb_pkg::t_op'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) begin
                x = 8'($urandom_range(0, 255));
                y = 8'($urandom_range(0, 255));
            end else begin
                v = $urandom_range(0, 142) - 15;
                x = v[7:0];
                v = $urandom_range(0, 110) - 15;
                y = v[7:0];
            end
            v = $urandom_range(0, 9);
            if (v < 7) begin
                ri = last_y * msrb_pkg::BYTES_PER_LINE + (last_x >>> 3)
                     + $urandom_range(0, 2);
            end else if (v < 9) begin
                ri = $urandom_range(0, msrb_pkg::FRAME_BYTES - 1);
            end else begin
                ri = $urandom_range(0, 2047);
            end
            if (op != msrb_pkg::OP_READ) begin
                last_x = x;
                last_y = y;
            end
            send_word(op, 16'($urandom_range(0, 65535)), x, y, ri[10:0]);
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.want_data.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (board.want_data.size() != 0) begin
            board.faults++;
            $display("%0t: %0d words still outstanding", $time, board.want_data.size());
        end
        if (board.faults == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
